>>> hw/rtl/bums_pkg.sv
// Shared types and constants for the bottom-up merge sorter.
`timescale 1ns / 1ps

package bums_pkg;

  // Width of one stored value.
  localparam int DATA_W = 32;

  // Sequencer states of the sorter.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_CHK,
    ST_RUN_INIT,
    ST_MRG_RD,
    ST_MRG_WR,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_HOLD
  } state_t;

endpackage

>>> hw/rtl/bottom_up_merge_sorter.sv
// Top level of the bottom-up merge sorter: collection, merge sequencer and output.
`timescale 1ns / 1ps
//
//  Channel   Handshake                        Payload
//  -------   ------------------------------   ----------------------------------------
//  sample    sample_valid / sample_stall      sample[31:0] signed, final_req
//  result    result_valid / result_stall      sorted_value[31:0] signed, end_of_set,
//                                             overflow
//
// Incoming words meet no stall while the set is being collected. Once the word
// marked final_req is taken, the set of n values is sorted by one shared compare unit
// that builds each merged value by reading both runs, then comparing and writing, over
// ceil(log2 n) passes. Each sorted word is then read, loaded into the output register
// and held until it is taken, through any result stall.
// Reset (rst, synchronous) empties the set and clears the dropped flag; the two
// buffers are not cleared and need no clearing pass. sample_stall stays high from the
// final word until the last sorted word has been taken.

module bottom_up_merge_sorter
  import bums_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     final_req,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     end_of_set,
  output logic                     overflow
);

  // Address width, count width (holds DEPTH itself), run width and sum widths.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = CW + 1;
  localparam int SW = CW + 2;

  state_t state, state_next;

  // Control registers.
  logic [CW-1:0] fill;       // Values held in the current set; also the sort length.
  logic          dropped;    // A value was dropped for lack of room.
  logic [WW-1:0] width;      // Run width of the current pass.
  logic          src;        // Buffer that holds the runs of the current pass.
  logic [CW-1:0] lo;         // Start of the current pair of runs.
  logic [CW-1:0] mid;        // End of the left run.
  logic [CW-1:0] hi;         // End of the right run.
  logic [CW-1:0] i;          // Read index in the left run, or emit index.
  logic [CW-1:0] j;          // Read index in the right run.
  logic [CW-1:0] k;          // Write index of the merged run.

  // Buffer ports.
  logic              we0, we1;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] r0a, r0b, r1a, r1b;
  logic [DATA_W-1:0] rd_a, rd_b;

  logic          sample_acc;
  logic          result_acc;
  logic          room;
  logic [SW-1:0] sum_mid;
  logic [SW-1:0] sum_hi;
  logic [CW-1:0] mid_c;
  logic [CW-1:0] hi_c;
  logic          take_left;
  logic [DATA_W-1:0] merge_val;

  assign sample_acc = sample_valid && !sample_stall;
  assign result_acc = result_valid && !result_stall;
  assign room       = (fill < CW'(DEPTH));

  // Bounds of the next pair of runs, clipped to the set length.
  assign sum_mid = {2'b00, lo} + {1'b0, width};
  assign sum_hi  = {2'b00, lo} + {width, 1'b0};
  assign mid_c   = (sum_mid < {2'b00, fill}) ? sum_mid[CW-1:0] : fill;
  assign hi_c    = (sum_hi  < {2'b00, fill}) ? sum_hi[CW-1:0]  : fill;

  // The source buffer of the pass feeds the shared compare unit.
  assign rd_a = src ? r1a : r0a;
  assign rd_b = src ? r1b : r0b;

  // Stable merge: the left run wins a tie, and an exhausted run never wins.
  assign take_left = (i < mid) && ((j >= hi) || ($signed(rd_a) <= $signed(rd_b)));
  assign merge_val = take_left ? rd_a : rd_b;

  bums_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (i[AW-1:0]),
    .raddr_b (j[AW-1:0]),
    .rdata_a (r0a),
    .rdata_b (r0b)
  );

  bums_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (i[AW-1:0]),
    .raddr_b (j[AW-1:0]),
    .rdata_a (r1a),
    .rdata_b (r1b)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_acc && final_req) begin
          state_next = ST_PASS_CHK;
        end
      end
      ST_PASS_CHK: begin
        // Passes continue while a run is shorter than the whole set.
        if (width < {1'b0, fill}) begin
          state_next = ST_RUN_INIT;
        end else begin
          state_next = ST_EM_RD;
        end
      end
      ST_RUN_INIT: begin
        if (lo < fill) begin
          state_next = ST_MRG_RD;
        end else begin
          state_next = ST_PASS_CHK;
        end
      end
      ST_MRG_RD: begin
        if (k == hi) begin
          state_next = ST_RUN_INIT;
        end else begin
          state_next = ST_MRG_WR;
        end
      end
      ST_MRG_WR: state_next = ST_MRG_RD;
      ST_EM_RD:  state_next = ST_EM_LD;
      ST_EM_LD:  state_next = ST_EM_HOLD;
      ST_EM_HOLD: begin
        if (result_acc) begin
          state_next = end_of_set ? ST_IDLE : ST_EM_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and buffer write controls.
  always_comb begin
    sample_stall = 1'b1;
    we0          = 1'b0;
    we1          = 1'b0;
    waddr        = k[AW-1:0];
    wdata        = merge_val;
    case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        we0          = sample_acc && room;
        waddr        = fill[AW-1:0];
        wdata        = sample;
      end
      ST_MRG_WR: begin
        we0 = src;
        we1 = !src;
      end
      default: begin
        sample_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      dropped      <= 1'b0;
      width        <= WW'(1);
      src          <= 1'b0;
      lo           <= '0;
      mid          <= '0;
      hi           <= '0;
      i            <= '0;
      j            <= '0;
      k            <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (sample_acc) begin
            if (room) begin
              fill <= fill + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            // A closed set always starts sorting from the collection buffer.
            width <= WW'(1);
            src   <= 1'b0;
            lo    <= '0;
          end
        end
        ST_PASS_CHK: begin
          i <= '0;
        end
        ST_RUN_INIT: begin
          if (lo < fill) begin
            mid <= mid_c;
            hi  <= hi_c;
            i   <= lo;
            j   <= mid_c;
            k   <= lo;
          end else begin
            // The pass is done: the merged runs become the next source.
            width <= {width[WW-2:0], 1'b0};
            src   <= !src;
            lo    <= '0;
          end
        end
        ST_MRG_RD: begin
          if (k == hi) begin
            lo <= hi;
          end
        end
        ST_MRG_WR: begin
          k <= k + CW'(1);
          if (take_left) begin
            i <= i + CW'(1);
          end else begin
            j <= j + CW'(1);
          end
        end
        ST_EM_LD: begin
          result_valid <= 1'b1;
          sorted_value <= rd_a;
          end_of_set   <= (({1'b0, i} + WW'(1)) == {1'b0, fill});
          overflow     <= dropped;
        end
        ST_EM_HOLD: begin
          if (result_acc) begin
            result_valid <= 1'b0;
            i            <= i + CW'(1);
            if (end_of_set) begin
              fill    <= '0;
              dropped <= 1'b0;
            end
          end
        end
        default: begin
          result_valid <= result_valid;
        end
      endcase
    end
  end

  // The set never grows beyond the buffer.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count exceeds buffer depth");

  // A result word is offered only while the sequencer waits for it to be taken.
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == ST_EM_HOLD))
    else $error("result offered outside the emit hold state");

  // A merge write never runs past the end of its pair of runs.
  a_merge_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MRG_WR) |-> ((k < hi) && (k >= lo)))
    else $error("merge write index out of run bounds");

  // Taking the last word of a set empties the set and clears the dropped flag.
  a_set_close: assert property (@(posedge clk) disable iff (rst)
    (result_acc && end_of_set) |=> ((fill == '0) && !dropped && (state == ST_IDLE)))
    else $error("set not closed after its last word");

endmodule

>>> hw/rtl/bums_ram.sv
// Value buffer with one write port and two registered read ports.
`timescale 1ns / 1ps

module bums_ram
  import bums_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Both read ports are registered: data for an address appears in the cycle after it.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
